// ----- rtl/stpt_pkg.sv -----
// Shared constants, codes and types of the segmented transfer part tracker.
package stpt_pkg;

   localparam int MAX_PARTS = 4096;
   localparam int IDX_W = 12;
   localparam int WORD_BITS = 64;
   localparam int BIT_W = 6;
   localparam int WORDS = MAX_PARTS / WORD_BITS;
   localparam int WADDR_W = 6;
   localparam int WCNT_W = WADDR_W + 1;

   localparam logic [15:0] DEFAULT_PART_BYTES = 16'd512;
   localparam logic [20:0] BUF_MAX = 21'd1048576;
   localparam logic [20:0] BUF_RESET = 21'd1048576;
   localparam logic [15:0] PART_RESET = 16'd512;
   localparam int DIV_STEPS = 20;
   localparam int DIV_CNT_W = 5;

   localparam logic CSR_BUFFER_BYTES = 1'b0;
   localparam logic CSR_PART_BYTES = 1'b1;

   localparam logic [2:0] FN_ADD = 3'd0;
   localparam logic [2:0] FN_TAKE = 3'd1;
   localparam logic [2:0] FN_FIND = 3'd2;
   localparam logic [2:0] FN_CREATE = 3'd3;
   localparam logic [2:0] FN_LOAD = 3'd4;
   localparam logic [2:0] FN_FREE = 3'd5;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_REWRITE = 3'd1;
   localparam logic [2:0] ST_BADLEN = 3'd2;
   localparam logic [2:0] ST_RANGE = 3'd3;
   localparam logic [2:0] ST_NOBUF = 3'd4;
   localparam logic [2:0] ST_NONE = 3'd5;
   localparam logic [2:0] ST_TOOMANY = 3'd6;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_ADD_RD  = 8'b0000_0010,
      S_ADD_CHK = 8'b0000_0100,
      S_SCAN    = 8'b0000_1000,
      S_DIV     = 8'b0001_0000,
      S_FILL    = 8'b0010_0000,
      S_OFFSET  = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

endpackage

// ----- rtl/stpt_if.sv -----
// Request and response channel interfaces of the part tracker.
interface stpt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [15:0] part_index;
   logic [15:0] payload_length;

   modport source (output valid, func, part_index, payload_length, input ready);
   modport sink (input valid, func, part_index, payload_length, output ready);
   modport monitor (input valid, ready, func, part_index, payload_length);
endinterface

interface stpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [11:0] found_index;
   logic [19:0] byte_offset;
   logic [15:0] part_length;

   modport source (output valid, status, found_index, byte_offset, part_length, input ready);
   modport sink (input valid, status, found_index, byte_offset, part_length, output ready);
   modport monitor (input valid, ready, status, found_index, byte_offset, part_length);
endinterface

// ----- rtl/stpt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/segmented_transfer_part_tracker.sv -----
// Steps: add reads and checks the mark word, then computes the offset; free and the rejects
// other than a bad length go straight to the result; take/find scan the 64-part mark words
// in turn; create/load run the divider, sweep the whole mark RAM, then compute the offset. One item at a time.
// Throughput: a new word is taken once the previous result is in the output register.
// Reset (synchronous): no buffer, config back to defaults; the mark RAM is not
// cleared, every accepted create/load sweeps all of it before it is read.
module segmented_transfer_part_tracker (
   input  logic              clock,
   input  logic              reset,
   stpt_req_if.sink          req_chan,
   stpt_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [20:0]       csr_wdata
);

   localparam int WB = stpt_pkg::WORD_BITS;
   localparam int BW = stpt_pkg::BIT_W;
   localparam int AW = stpt_pkg::WADDR_W;
   localparam int CW = stpt_pkg::WCNT_W;
   localparam int IW = stpt_pkg::IDX_W;

   stpt_pkg::state_type state_ff, state_in;

   logic [20:0] buffer_bytes_ff;
   logic [15:0] part_bytes_ff;

   logic          created_ff, created_in;
   logic          read_en_ff, read_en_in;
   logic [IW-1:0] last_index_ff, last_index_in;
   logic [15:0]   last_length_ff, last_length_in;
   logic          load_ff, load_in;
   logic          take_ff, take_in;
   logic [15:0]   idx_ff, idx_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          rv_ff, rv_in;
   logic [AW-1:0] rq_ff, rq_in;
   logic [19:0]   quo_ff, quo_in;
   logic [15:0]   rem_ff, rem_in;
   logic [stpt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [2:0]    res_status_ff, res_status_in;
   logic [IW-1:0] res_index_ff, res_index_in;
   logic [19:0]   res_off_ff, res_off_in;
   logic [15:0]   res_len_ff, res_len_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [IW-1:0] rsp_index_ff, rsp_index_in;
   logic [19:0]   rsp_off_ff, rsp_off_in;
   logic [15:0]   rsp_len_ff, rsp_len_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [WB-1:0] ram_wdata, ram_rdata;

   logic [15:0]   psize;
   logic [15:0]   req_len_exp;
   logic [AW-1:0] last_word;
   logic [BW-1:0] last_bit;
   logic [WB-1:0] hi_mask, fill_mask, lo_mask, scan_word, scan_hits, bit_sel;
   logic [BW-1:0] hit_pos;
   logic          scan_hit, scan_issue, out_load;
   logic [16:0]   trial;
   logic          trial_ge;
   logic [19:0]   quo_next;
   logic [15:0]   rem_next;
   logic [27:0]   prod;

   stpt_ram #(.WIDTH(WB), .DEPTH(stpt_pkg::WORDS)) u_marks (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign psize = (part_bytes_ff == 16'd0) ? stpt_pkg::DEFAULT_PART_BYTES : part_bytes_ff;
   assign req_len_exp = (req_chan.part_index[IW-1:0] == last_index_ff) ? last_length_ff : psize;
   assign last_word = last_index_ff[IW-1:BW];
   assign last_bit = last_index_ff[BW-1:0];
   assign hi_mask = {WB{1'b1}} >> (BW'(WB - 1) - last_bit);

   // load sets only the marks up to the last part
   always_comb begin
      if (addr_ff[AW-1:0] < last_word) begin
         fill_mask = {WB{1'b1}};
      end else if (addr_ff[AW-1:0] == last_word) begin
         fill_mask = hi_mask;
      end else begin
         fill_mask = '0;
      end
   end

   assign scan_word = take_ff ? ram_rdata : ~ram_rdata;
   assign lo_mask = (!take_ff && rq_ff == idx_ff[IW-1:BW]) ?
                    ({WB{1'b1}} << idx_ff[BW-1:0]) : {WB{1'b1}};
   assign scan_hits = scan_word & lo_mask & ((rq_ff == last_word) ? hi_mask : {WB{1'b1}});
   assign scan_hit = |scan_hits;

   always_comb begin
      hit_pos = '0;
      for (int k = WB - 1; k >= 0; k--) begin
         if (scan_hits[k]) begin
            hit_pos = BW'(k);
         end
      end
   end

   assign bit_sel = {{(WB-1){1'b0}}, 1'b1} << hit_pos;
   assign scan_issue = (addr_ff <= {1'b0, last_word});

   // restoring divide of (buffer_bytes - 1) by the part size, one bit a cycle
   assign trial = {rem_ff, quo_ff[19]};
   assign trial_ge = (trial >= {1'b0, psize});
   assign rem_next = trial_ge ? 16'(trial - {1'b0, psize}) : trial[15:0];
   assign quo_next = {quo_ff[18:0], trial_ge};

   assign prod = res_index_ff * psize;

   assign out_load = (state_ff == stpt_pkg::S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == stpt_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      created_in = created_ff;
      read_en_in = read_en_ff;
      last_index_in = last_index_ff;
      last_length_in = last_length_ff;
      load_in = load_ff;
      take_in = take_ff;
      idx_in = idx_ff;
      addr_in = addr_ff;
      rv_in = 1'b0;
      rq_in = addr_ff[AW-1:0];
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      res_status_in = res_status_ff;
      res_index_in = res_index_ff;
      res_off_in = res_off_ff;
      res_len_in = res_len_ff;
      ram_we = 1'b0;
      ram_waddr = addr_ff[AW-1:0];
      ram_wdata = '0;
      ram_re = 1'b0;
      ram_raddr = addr_ff[AW-1:0];

      unique case (state_ff)
         stpt_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               idx_in = req_chan.part_index;
               res_index_in = '0;
               res_off_in = '0;
               res_len_in = '0;
               res_status_in = stpt_pkg::ST_RANGE;
               state_in = stpt_pkg::S_DONE;
               addr_in = '0;
               unique case (req_chan.func) inside
                  stpt_pkg::FN_ADD: begin
                     if (!created_ff) begin
                        res_status_in = stpt_pkg::ST_NOBUF;
                     end else if (req_chan.part_index > {4'd0, last_index_ff}) begin
                        res_status_in = stpt_pkg::ST_RANGE;
                     end else if (req_chan.payload_length != req_len_exp) begin
                        res_status_in = stpt_pkg::ST_BADLEN;
                        res_index_in = req_chan.part_index[IW-1:0];
                        state_in = stpt_pkg::S_OFFSET;
                     end else begin
                        state_in = stpt_pkg::S_ADD_RD;
                     end
                  end
                  stpt_pkg::FN_TAKE: begin
                     take_in = 1'b1;
                     if (!created_ff || !read_en_ff) begin
                        res_status_in = stpt_pkg::ST_NOBUF;
                     end else begin
                        state_in = stpt_pkg::S_SCAN;
                     end
                  end
                  stpt_pkg::FN_FIND: begin
                     take_in = 1'b0;
                     if (!created_ff) begin
                        res_status_in = stpt_pkg::ST_NOBUF;
                     end else if (req_chan.part_index > {4'd0, last_index_ff}) begin
                        res_status_in = stpt_pkg::ST_NONE;
                     end else begin
                        addr_in = {1'b0, req_chan.part_index[IW-1:BW]};
                        state_in = stpt_pkg::S_SCAN;
                     end
                  end
                  stpt_pkg::FN_CREATE, stpt_pkg::FN_LOAD: begin
                     load_in = (req_chan.func == stpt_pkg::FN_LOAD);
                     created_in = 1'b0;
                     read_en_in = 1'b0;
                     last_index_in = '0;
                     last_length_in = '0;
                     if (buffer_bytes_ff == 21'd0 || buffer_bytes_ff > stpt_pkg::BUF_MAX) begin
                        res_status_in = stpt_pkg::ST_RANGE;
                     end else begin
                        quo_in = 20'(buffer_bytes_ff - 21'd1);
                        rem_in = '0;
                        cnt_in = '0;
                        state_in = stpt_pkg::S_DIV;
                     end
                  end
                  stpt_pkg::FN_FREE: begin
                     if (!created_ff) begin
                        res_status_in = stpt_pkg::ST_NOBUF;
                     end else begin
                        created_in = 1'b0;
                        read_en_in = 1'b0;
                        res_status_in = stpt_pkg::ST_OK;
                     end
                  end
                  default: res_status_in = stpt_pkg::ST_RANGE;
               endcase
            end
         end
         stpt_pkg::S_ADD_RD: begin
            ram_re = 1'b1;
            ram_raddr = idx_ff[IW-1:BW];
            state_in = stpt_pkg::S_ADD_CHK;
         end
         stpt_pkg::S_ADD_CHK: begin
            res_index_in = idx_ff[IW-1:0];
            if (ram_rdata[idx_ff[BW-1:0]]) begin
               res_status_in = stpt_pkg::ST_REWRITE;
            end else begin
               res_status_in = stpt_pkg::ST_OK;
               ram_we = 1'b1;
               ram_waddr = idx_ff[IW-1:BW];
               ram_wdata = ram_rdata | ({{(WB-1){1'b0}}, 1'b1} << idx_ff[BW-1:0]);
            end
            state_in = stpt_pkg::S_OFFSET;
         end
         stpt_pkg::S_SCAN: begin
            // issue one word a cycle, judge the word read the cycle before
            ram_re = scan_issue;
            rv_in = scan_issue;
            if (scan_issue) begin
               addr_in = addr_ff + CW'(1);
            end
            if (rv_ff) begin
               if (scan_hit) begin
                  rv_in = 1'b0;
                  res_status_in = stpt_pkg::ST_OK;
                  res_index_in = {rq_ff, hit_pos};
                  if (take_ff) begin
                     ram_we = 1'b1;
                     ram_waddr = rq_ff;
                     ram_wdata = ram_rdata & ~bit_sel;
                  end
                  state_in = stpt_pkg::S_OFFSET;
               end else if (rq_ff == last_word) begin
                  rv_in = 1'b0;
                  res_status_in = stpt_pkg::ST_NONE;
                  res_index_in = '0;
                  res_off_in = '0;
                  res_len_in = '0;
                  state_in = stpt_pkg::S_DONE;
               end
            end
         end
         stpt_pkg::S_DIV: begin
            quo_in = quo_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + stpt_pkg::DIV_CNT_W'(1);
            if (cnt_ff == stpt_pkg::DIV_CNT_W'(stpt_pkg::DIV_STEPS - 1)) begin
               if (quo_next[19:IW] != '0) begin
                  res_status_in = stpt_pkg::ST_TOOMANY;
                  state_in = stpt_pkg::S_DONE;
               end else begin
                  last_index_in = quo_next[IW-1:0];
                  last_length_in = rem_next + 16'd1;
                  addr_in = '0;
                  state_in = stpt_pkg::S_FILL;
               end
            end
         end
         stpt_pkg::S_FILL: begin
            ram_we = 1'b1;
            ram_waddr = addr_ff[AW-1:0];
            ram_wdata = load_ff ? fill_mask : '0;
            addr_in = addr_ff + CW'(1);
            if (addr_ff == CW'(stpt_pkg::WORDS - 1)) begin
               created_in = 1'b1;
               read_en_in = load_ff;
               res_status_in = stpt_pkg::ST_OK;
               res_index_in = last_index_ff;
               state_in = stpt_pkg::S_OFFSET;
            end
         end
         stpt_pkg::S_OFFSET: begin
            res_off_in = prod[19:0];
            res_len_in = (res_index_ff == last_index_ff) ? last_length_ff : psize;
            state_in = stpt_pkg::S_DONE;
         end
         stpt_pkg::S_DONE: begin
            if (out_load) begin
               state_in = stpt_pkg::S_IDLE;
            end
         end
         default: state_in = stpt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_off_in = rsp_off_ff;
      rsp_len_in = rsp_len_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_index_in = res_index_ff;
         rsp_off_in = res_off_ff;
         rsp_len_in = res_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stpt_pkg::S_IDLE;
         created_ff <= 1'b0;
         read_en_ff <= 1'b0;
         last_index_ff <= '0;
         last_length_ff <= '0;
         rv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         buffer_bytes_ff <= stpt_pkg::BUF_RESET;
         part_bytes_ff <= stpt_pkg::PART_RESET;
      end else begin
         state_ff <= state_in;
         created_ff <= created_in;
         read_en_ff <= read_en_in;
         last_index_ff <= last_index_in;
         last_length_ff <= last_length_in;
         rv_ff <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == stpt_pkg::CSR_BUFFER_BYTES) begin
               buffer_bytes_ff <= csr_wdata;
            end else begin
               part_bytes_ff <= csr_wdata[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      load_ff <= load_in;
      take_ff <= take_in;
      idx_ff <= idx_in;
      addr_ff <= addr_in;
      rq_ff <= rq_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      res_status_ff <= res_status_in;
      res_index_ff <= res_index_in;
      res_off_ff <= res_off_in;
      res_len_ff <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff <= rsp_index_in;
      rsp_off_ff <= rsp_off_in;
      rsp_len_ff <= rsp_len_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.found_index = rsp_index_ff;
   assign rsp_chan.byte_offset = rsp_off_ff;
   assign rsp_chan.part_length = rsp_len_ff;

`ifndef ASSERT_OFF
   a_mark_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == stpt_pkg::S_ADD_CHK || state_ff == stpt_pkg::S_SCAN ||
                  state_ff == stpt_pkg::S_FILL))
      else $error("mark RAM written outside add, take or fill");

   a_created_after_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(created_ff) |-> $past(state_ff) == stpt_pkg::S_FILL)
      else $error("buffer created without a mark sweep");

   a_reject_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == stpt_pkg::ST_RANGE ||
                        rsp_status_ff == stpt_pkg::ST_NOBUF ||
                        rsp_status_ff == stpt_pkg::ST_NONE ||
                        rsp_status_ff == stpt_pkg::ST_TOOMANY))
      |-> (rsp_index_ff == '0 && rsp_off_ff == '0 && rsp_len_ff == '0))
      else $error("rejected word carries nonzero fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=>
      (rsp_valid_ff && $stable(rsp_status_ff) && $stable(rsp_index_ff) &&
       $stable(rsp_off_ff) && $stable(rsp_len_ff)))
      else $error("stalled response word changed");
`endif

endmodule

// ----- bench/stpt_checker.sv -----
// Checker of the part tracker: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module stpt_checker (
   input  logic        clock,
   input  logic        reset,
   stpt_req_if.monitor req_mon,
   stpt_rsp_if.monitor rsp_mon,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata,
   output int          error_count,
   output int          pending_count,
   output int          word_count
);

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] found_index;
      logic [19:0] byte_offset;
      logic [15:0] part_length;
   } tracker_result_type;

   tracker_result_type expected_results[$];

   logic [20:0] buf_bytes;
   logic [15:0] part_bytes_reg;
   bit          have_buffer;
   bit          readout_on;
   bit          marks [stpt_pkg::MAX_PARTS];
   int unsigned final_idx;
   int unsigned final_len;

   assign pending_count = expected_results.size();

   function automatic int unsigned live_part_size();
      return (part_bytes_reg == 16'd0) ? 32'(stpt_pkg::DEFAULT_PART_BYTES) :
                                         32'(part_bytes_reg);
   endfunction

   function automatic int unsigned length_of_part(int unsigned i);
      return (i == final_idx) ? final_len : live_part_size();
   endfunction

   function automatic tracker_result_type pack_result(logic [2:0] st, int unsigned i,
                                                      bit with_part);
      tracker_result_type r;
      longint unsigned off;
      r = '0;
      r.status = st;
      if (with_part) begin
         off = longint'(i) * live_part_size();
         r.found_index = i[11:0];
         r.byte_offset = off[19:0];
         r.part_length = 16'(length_of_part(i));
      end
      return r;
   endfunction

   function automatic tracker_result_type build_buffer(bit fill);
      int unsigned psz;
      int unsigned parts;
      psz = live_part_size();
      have_buffer = 0;
      readout_on = 0;
      final_idx = 0;
      final_len = 0;
      if (buf_bytes == 0 || buf_bytes > stpt_pkg::BUF_MAX)
         return pack_result(stpt_pkg::ST_RANGE, 0, 0);
      parts = (buf_bytes + psz - 1) / psz;
      if (parts > stpt_pkg::MAX_PARTS) return pack_result(stpt_pkg::ST_TOOMANY, 0, 0);
      final_idx = parts - 1;
      final_len = buf_bytes - final_idx * psz;
      for (int k = 0; k < stpt_pkg::MAX_PARTS; k++) marks[k] = fill && (k < parts);
      have_buffer = 1;
      readout_on = fill;
      return pack_result(stpt_pkg::ST_OK, final_idx, 1);
   endfunction

   function automatic tracker_result_type track_word(logic [2:0] fn, int unsigned idx,
                                                     int unsigned len);
      case (fn)
         stpt_pkg::FN_ADD: begin
            if (!have_buffer) return pack_result(stpt_pkg::ST_NOBUF, 0, 0);
            if (idx > final_idx) return pack_result(stpt_pkg::ST_RANGE, 0, 0);
            if (len != length_of_part(idx)) return pack_result(stpt_pkg::ST_BADLEN, idx, 1);
            if (marks[idx]) return pack_result(stpt_pkg::ST_REWRITE, idx, 1);
            marks[idx] = 1;
            return pack_result(stpt_pkg::ST_OK, idx, 1);
         end
         stpt_pkg::FN_TAKE: begin
            if (!have_buffer || !readout_on) return pack_result(stpt_pkg::ST_NOBUF, 0, 0);
            for (int unsigned i = 0; i <= final_idx; i++)
               if (marks[i]) begin
                  marks[i] = 0;
                  return pack_result(stpt_pkg::ST_OK, i, 1);
               end
            return pack_result(stpt_pkg::ST_NONE, 0, 0);
         end
         stpt_pkg::FN_FIND: begin
            if (!have_buffer) return pack_result(stpt_pkg::ST_NOBUF, 0, 0);
            for (int unsigned i = idx; i <= final_idx; i++)
               if (!marks[i]) return pack_result(stpt_pkg::ST_OK, i, 1);
            return pack_result(stpt_pkg::ST_NONE, 0, 0);
         end
         stpt_pkg::FN_CREATE: return build_buffer(0);
         stpt_pkg::FN_LOAD: return build_buffer(1);
         stpt_pkg::FN_FREE: begin
            if (!have_buffer) return pack_result(stpt_pkg::ST_NOBUF, 0, 0);
            have_buffer = 0;
            readout_on = 0;
            return pack_result(stpt_pkg::ST_OK, 0, 0);
         end
         default: return pack_result(stpt_pkg::ST_RANGE, 0, 0);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      tracker_result_type got;
      tracker_result_type want;
      if (reset) begin
         buf_bytes <= stpt_pkg::BUF_RESET;
         part_bytes_reg <= stpt_pkg::PART_RESET;
         have_buffer = 0;
         readout_on = 0;
         final_idx = 0;
         final_len = 0;
         for (int k = 0; k < stpt_pkg::MAX_PARTS; k++) marks[k] = 0;
         expected_results.delete();
         error_count = 0;
         word_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == stpt_pkg::CSR_BUFFER_BYTES) buf_bytes <= csr_wdata;
            else part_bytes_reg <= csr_wdata[15:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.status, rsp_mon.found_index, rsp_mon.byte_offset,
                   rsp_mon.part_length};
            word_count++;
            if (expected_results.size() == 0)
               report_mismatch("unexpected word", 64'(got), 64'd0);
            else begin
               want = expected_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.found_index != want.found_index)
                  report_mismatch("found_index", 64'(got.found_index),
                                  64'(want.found_index));
               if (got.byte_offset != want.byte_offset)
                  report_mismatch("byte_offset", 64'(got.byte_offset),
                                  64'(want.byte_offset));
               if (got.part_length != want.part_length)
                  report_mismatch("part_length", 64'(got.part_length),
                                  64'(want.part_length));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(track_word(req_mon.func, req_mon.part_index,
                                                  req_mon.payload_length));
      end
   end

endmodule

// ----- bench/tb.sv -----
// Top of the part tracker bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [20:0] csr_wdata;
   int          error_count;
   int          pending_count;
   int          word_count;
   int          send_idle_pct;
   int          stall_pct;
   bit          hold_off;
   int          fn_seen [8];

   stpt_req_if req_chan ();
   stpt_rsp_if rsp_chan ();

   segmented_transfer_part_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stpt_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.monitor),
      .rsp_mon       (rsp_chan.monitor),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .word_count    (word_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: random stalls, or a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   // Valid stays up from one word to the next unless the sender idles.
   task automatic send_word(logic [2:0] fn, logic [15:0] idx, logic [15:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= fn;
      req_chan.part_index <= idx;
      req_chan.payload_length <= len;
      fn_seen[fn]++;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid and let the checker see the last word before waiting it out.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Wait out outstanding words and the longest operation before a register write.
   task automatic drain_then_write(logic idx, logic [20:0] val);
      wait_idle();
      repeat (120) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_sizes(logic [20:0] bytes, logic [15:0] psz);
      drain_then_write(stpt_pkg::CSR_BUFFER_BYTES, bytes);
      drain_then_write(stpt_pkg::CSR_PART_BYTES, {5'd0, psz});
   endtask

   // Mostly well-formed traffic on the current buffer with some noise.
   task automatic random_words(int count, int unsigned parts, int unsigned psz,
                               int unsigned tail);
      int unsigned sel;
      int unsigned idx;
      int unsigned len;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         idx = $urandom_range(parts - 1);
         len = (idx == parts - 1) ? tail : psz;
         if (sel < 45) send_word(stpt_pkg::FN_ADD, 16'(idx), 16'(len));
         else if (sel < 52) send_word(stpt_pkg::FN_ADD, 16'(idx), 16'($urandom_range(65535)));
         else if (sel < 56) send_word(stpt_pkg::FN_ADD, 16'($urandom_range(65535)),
                                      16'($urandom_range(65535)));
         else if (sel < 72) send_word(stpt_pkg::FN_TAKE, 16'($urandom_range(65535)),
                                      16'($urandom_range(65535)));
         else if (sel < 88) send_word(stpt_pkg::FN_FIND, 16'($urandom_range(parts)),
                                      16'($urandom_range(65535)));
         else if (sel < 90) send_word(stpt_pkg::FN_FIND, 16'($urandom_range(65535)), 16'd0);
         else if (sel < 93) send_word(stpt_pkg::FN_LOAD, 16'd0, 16'd0);
         else if (sel < 95) send_word(stpt_pkg::FN_CREATE, 16'd0, 16'd0);
         else if (sel < 96) send_word(stpt_pkg::FN_FREE, 16'd0, 16'd0);
         else if (sel < 98) send_word(3'($urandom_range(7)), 16'($urandom_range(65535)),
                                      16'($urandom_range(65535)));
         else send_word(3'(6 + $urandom_range(1)), 16'hFFFF, 16'hFFFF);
      end
   endtask

   task automatic run_phase(int idle, int stall, int count);
      int unsigned bytes;
      int unsigned psz;
      int unsigned parts;
      send_idle_pct = idle;
      stall_pct = stall;
      for (int blk = 0; blk < count / 50; blk++) begin
         psz = ($urandom_range(3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 300);
         bytes = $urandom_range(1, (psz * 40 > 1048576) ? 1048576 : psz * 40);
         if (blk % 7 == 3) bytes = $urandom_range(1, 1048576);
         set_sizes(21'(bytes), 16'(psz));
         parts = (bytes + psz - 1) / psz;
         if (parts > stpt_pkg::MAX_PARTS) begin
            send_word(stpt_pkg::FN_CREATE, 16'd0, 16'd0);
            set_sizes(21'(bytes), 16'd512);
            psz = 512;
            parts = (bytes + psz - 1) / psz;
         end
         send_word($urandom_range(1) ? stpt_pkg::FN_CREATE : stpt_pkg::FN_LOAD, 16'd0, 16'd0);
         random_words(50, parts, psz, bytes - (parts - 1) * psz);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = stpt_pkg::FN_ADD;
      req_chan.part_index = '0;
      req_chan.payload_length = '0;
      csr_we = 1'b0;
      csr_index = stpt_pkg::CSR_BUFFER_BYTES;
      csr_wdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no buffer, default sizes, edges of the fields.
      send_word(stpt_pkg::FN_ADD, 16'd0, 16'd512);
      send_word(stpt_pkg::FN_TAKE, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_FIND, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_FREE, 16'd0, 16'd0);
      send_word(3'd6, 16'd0, 16'd0);
      send_word(3'd7, 16'hFFFF, 16'hFFFF);
      send_word(stpt_pkg::FN_CREATE, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_ADD, 16'd2047, 16'd512);
      send_word(stpt_pkg::FN_ADD, 16'd2047, 16'd512);
      send_word(stpt_pkg::FN_ADD, 16'd5, 16'd511);
      send_word(stpt_pkg::FN_ADD, 16'd2048, 16'd512);
      send_word(stpt_pkg::FN_ADD, 16'hFFFF, 16'hFFFF);
      send_word(stpt_pkg::FN_TAKE, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_FIND, 16'd2047, 16'd0);
      send_word(stpt_pkg::FN_FIND, 16'hFFFF, 16'd0);
      send_word(stpt_pkg::FN_LOAD, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_TAKE, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_FREE, 16'd0, 16'd0);
      set_sizes(21'd0, 16'd0);
      send_word(stpt_pkg::FN_CREATE, 16'd0, 16'd0);
      set_sizes(21'd1048577, 16'd65535);
      send_word(stpt_pkg::FN_LOAD, 16'd0, 16'd0);
      set_sizes(21'd1048576, 16'd1);
      send_word(stpt_pkg::FN_CREATE, 16'd0, 16'd0);
      set_sizes(21'd4096, 16'd1);
      send_word(stpt_pkg::FN_LOAD, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_ADD, 16'd4095, 16'd1);
      set_sizes(21'd1000, 16'd300);
      send_word(stpt_pkg::FN_CREATE, 16'd0, 16'd0);
      send_word(stpt_pkg::FN_ADD, 16'd3, 16'd100);
      // Change part size after create: offsets follow the live value.
      drain_then_write(stpt_pkg::CSR_PART_BYTES, 21'd65535);
      send_word(stpt_pkg::FN_FIND, 16'd0, 16'd0);

      run_phase(0, 0, 400);
      run_phase(87, 0, 400);
      run_phase(0, 87, 400);
      run_phase(34, 34, 400);

      // Hold off the receiver long enough for the input to back up.
      set_sizes(21'd2000, 16'd100);
      send_idle_pct = 0;
      stall_pct = 0;
      send_word(stpt_pkg::FN_LOAD, 16'd0, 16'd0);
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         random_words(20, 20, 100, 100);
      join

      wait_idle();
      repeat (150) @(posedge clock);
      $display("words checked %0d: add %0d take %0d find %0d create %0d load %0d free %0d",
               word_count, fn_seen[0], fn_seen[1], fn_seen[2], fn_seen[3], fn_seen[4],
               fn_seen[5]);
      $display("unused codes %0d, under four idle and stall mixes and one long hold-off",
               fn_seen[6] + fn_seen[7]);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- segmented_transfer_part_tracker.f -----
rtl/stpt_pkg.sv
rtl/stpt_if.sv
rtl/stpt_ram.sv
rtl/segmented_transfer_part_tracker.sv
bench/stpt_checker.sv
bench/tb.sv
